// ===== hdl/gpr_pkg.sv =====
`timescale 1ns / 1ps
// Package for the glyph pixel renderer: font geometry constants and the
// 5x7 column-major font table. No dependencies.
package gpr_pkg;

  localparam logic [7:0] GlyphFirst = 8'h20;
  localparam logic [7:0] GlyphLast  = 8'h7E;
  localparam int GlyphCount = 95;
  localparam int GlyphCols  = 5;
  localparam int GlyphRows  = 7;
  localparam int GlyphBits  = GlyphCols * GlyphRows;
  localparam int GlyphIdxW  = $clog2(GlyphCount);

  // One entry per glyph: column 0 in the top byte, column 4 in the low byte.
  // Bit r of a column byte is row r, row 0 at the top.
  localparam logic [39:0] FontRom [GlyphCount] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
    40'h00007F0000, 40'h0041360800, 40'h1008081008
  };

endpackage

// ===== hdl/gpr_font_rom.sv =====
`timescale 1ns / 1ps
// Synchronous font ROM: one glyph read per cycle, registered output.
// Depends on gpr_pkg.
module gpr_font_rom (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic                          printable,
  input  logic [gpr_pkg::GlyphIdxW-1:0] glyph_index,
  output logic [gpr_pkg::GlyphBits-1:0] glyph_bits
);
  import gpr_pkg::*;

  logic [39:0] word;

  // Reorder to bit c*7+r so that bit order equals emission order.
  always_comb begin
    word = FontRom[glyph_index];
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      for (int c = 0; c < GlyphCols; c++) begin
        glyph_bits[c*GlyphRows +: GlyphRows] <=
          printable ? word[(39 - 8*c) - 1 -: GlyphRows] : '0;
      end
    end
  end

endmodule

// ===== hdl/glyph_pixel_renderer_core.sv =====
`timescale 1ns / 1ps
// Top level of the 5x7 character generator. Depends on gpr_pkg and
// gpr_font_rom.
//
// Each draw command (signed origin, ink color, character byte) becomes one
// pixel write per set glyph bit that lands on the screen, ordered column 0..4
// and within a column row 0..6; the final write carries last_pixel. Codes
// outside 0x20..0x7E, blank glyphs and fully clipped glyphs give no writes.
// A command is registered in the font ROM read stage, then the pixel
// walker emits one write per cycle, unless the output stalls, for each
// visible pixel (up to 35); a command with none leaves the walker empty.
// The walker's one-write-per-cycle loop sets the rate; the next command
// is taken and its glyph fetched while the current one is still drawing, and
// the walker advances on any cycle in which the output register is empty or
// is being taken by the sink; a held write stalls the walker.
// The first write passes through the fetch registers, walker mask and output register.
// pixel_address is row * SCREEN_WIDTH + column, low 16 bits kept.
module glyph_pixel_renderer_core #(
  parameter int SCREEN_WIDTH  = 256,
  parameter int SCREEN_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [9:0]  origin_x,
  input  logic [9:0]  origin_y,
  input  logic [31:0] ink_color,
  input  logic [7:0]  char_code,
  output logic        pix_valid,
  input  logic        pix_stall,
  output logic [15:0] pixel_address,
  output logic [31:0] pixel_color,
  output logic        last_pixel
);
  import gpr_pkg::*;

  localparam int AreaW = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT);
  localparam int ProdW = (AreaW > 16) ? AreaW : 16;

  // ---- fetch stage: command registers alongside the ROM read ----
  logic                 cmd_accept;
  logic                 printable;
  logic [GlyphIdxW-1:0] glyph_index;
  logic [GlyphBits-1:0] glyph_bits;
  logic                 fetch_valid;
  logic [9:0]           fetch_ox;
  logic [9:0]           fetch_oy;
  logic [31:0]          fetch_ink;

  // ---- walker stage: remaining visible pixels of the current command ----
  logic [GlyphBits-1:0] mask;
  logic [GlyphBits-1:0] mask_next;
  logic [GlyphBits-1:0] visible;
  logic [9:0]           walk_ox;
  logic [9:0]           walk_oy;
  logic [31:0]          walk_ink;
  logic                 walk_busy;
  logic                 walk_last;
  logic                 emit;
  logic                 load;
  logic [GlyphBits-1:0] pick;
  logic [2:0]           col_sel;
  logic [2:0]           row_sel;
  logic signed [11:0]   px;
  logic signed [11:0]   py;
  logic [ProdW-1:0]     addr_full;

  assign printable   = (char_code >= GlyphFirst) && (char_code <= GlyphLast);
  assign glyph_index = printable ? GlyphIdxW'(char_code - GlyphFirst) : '0;

  assign walk_busy = |mask;
  assign pick      = mask & (~mask + GlyphBits'(1));
  assign walk_last = (mask & ~pick) == '0;
  assign emit      = walk_busy && (!pix_valid || !pix_stall);
  // Fetch stage hands over when the walker is empty or finishing this cycle.
  assign load       = fetch_valid && (!walk_busy || (emit && walk_last));
  assign cmd_stall  = fetch_valid && !load;
  assign cmd_accept = cmd_valid && !cmd_stall;

  gpr_font_rom u_rom (
    .clk         (clk),
    .rd_en       (cmd_accept),
    .printable   (printable),
    .glyph_index (glyph_index),
    .glyph_bits  (glyph_bits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fetch_valid <= 1'b0;
    end else if (cmd_accept) begin
      fetch_valid <= 1'b1;
    end else if (load) begin
      fetch_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      fetch_ox  <= origin_x;
      fetch_oy  <= origin_y;
      fetch_ink <= ink_color;
    end
  end

  // Clip the fetched glyph against the screen: one check per column and row.
  always_comb begin
    logic signed [11:0] cx;
    logic signed [11:0] ry;
    logic [GlyphCols-1:0] col_ok;
    logic [GlyphRows-1:0] row_ok;
    for (int c = 0; c < GlyphCols; c++) begin
      cx = {{2{fetch_ox[9]}}, fetch_ox} + 12'(c);
      col_ok[c] = (cx >= 12'sd0) && (cx < $signed(12'(SCREEN_WIDTH)));
    end
    for (int r = 0; r < GlyphRows; r++) begin
      ry = {{2{fetch_oy[9]}}, fetch_oy} + 12'(r);
      row_ok[r] = (ry >= 12'sd0) && (ry < $signed(12'(SCREEN_HEIGHT)));
    end
    for (int c = 0; c < GlyphCols; c++) begin
      for (int r = 0; r < GlyphRows; r++) begin
        visible[c*GlyphRows + r] = glyph_bits[c*GlyphRows + r] & col_ok[c] & row_ok[r];
      end
    end
  end

  always_comb begin
    mask_next = mask;
    if (emit) begin
      mask_next = mask & ~pick;
    end
    if (load) begin
      mask_next = visible;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else begin
      mask <= mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      walk_ox  <= fetch_ox;
      walk_oy  <= fetch_oy;
      walk_ink <= fetch_ink;
    end
  end

  // Column and row of the lowest pending pixel.
  always_comb begin
    col_sel = '0;
    row_sel = '0;
    for (int k = 0; k < GlyphBits; k++) begin
      if (pick[k]) begin
        col_sel = col_sel | 3'(k / GlyphRows);
        row_sel = row_sel | 3'(k % GlyphRows);
      end
    end
  end

  assign px = {{2{walk_ox[9]}}, walk_ox} + {9'd0, col_sel};
  assign py = {{2{walk_oy[9]}}, walk_oy} + {9'd0, row_sel};
  // Visible pixels have 0 <= px,py < 1024.
  assign addr_full = ProdW'(py[9:0]) * ProdW'(SCREEN_WIDTH) + ProdW'(px[9:0]);

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (emit) begin
      pix_valid <= 1'b1;
    end else if (!pix_stall) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_address <= addr_full[15:0];
      pixel_color   <= walk_ink;
      last_pixel    <= walk_last;
    end
  end

  // ---- checks ----
  a_emit_one_pixel : assert property (@(posedge clk) disable iff (rst)
    emit |-> $onehot(pick))
    else $error("walker emitted without exactly one pending pixel");

  a_no_overwrite_walk : assert property (@(posedge clk) disable iff (rst)
    (load && walk_busy) |-> (emit && walk_last))
    else $error("new glyph loaded over unfinished pixels");

  a_hold_stalled_out : assert property (@(posedge clk) disable iff (rst)
    (pix_valid && pix_stall) |-> !emit)
    else $error("output register overwritten while stalled");

  a_fetch_free_takes : assert property (@(posedge clk) disable iff (rst)
    !fetch_valid |-> !cmd_stall)
    else $error("command stalled with empty fetch stage");

endmodule

// ===== dv/glyph_pixel_renderer_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the 5x7 character generator: predicts the pixel writes of
// every accepted draw command and compares the write channel against them.
// Depends on gpr_pkg for the printable code range only.
module glyph_pixel_renderer_checker #(
  parameter int SCREEN_WIDTH  = 256,
  parameter int SCREEN_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  input  logic        cmd_stall,
  input  logic [9:0]  origin_x,
  input  logic [9:0]  origin_y,
  input  logic [31:0] ink_color,
  input  logic [7:0]  char_code,
  input  logic        pix_valid,
  input  logic        pix_stall,
  input  logic [15:0] pixel_address,
  input  logic [31:0] pixel_color,
  input  logic        last_pixel,
  output int          fail_count,
  output int          writes_pending,
  output int          writes_checked
);
  import gpr_pkg::*;

  // Column 0 in the top byte; bit r of a column is row r.
  localparam logic [39:0] GlyphBitmaps [95] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
    40'h00007F0000, 40'h0041360800, 40'h1008081008
  };

  typedef struct packed {
    logic [15:0] address;
    logic [31:0] color;
    logic        is_last;
  } pixel_write_t;

  pixel_write_t expected_writes [$];
  int errors  = 0;
  int checked = 0;

  // Expands one draw command into its on-screen pixel writes.
  function automatic void render_glyph(input logic [9:0] ox_raw, input logic [9:0] oy_raw,
                                       input logic [31:0] ink, input logic [7:0] code);
    int ox, oy, px, py, col, row;
    logic [39:0] bitmap;
    logic [7:0] column;
    pixel_write_t glyph_writes [$];
    pixel_write_t w;
    if (code < GlyphFirst || code > GlyphLast) return;
    ox = $signed(ox_raw);
    oy = $signed(oy_raw);
    bitmap = GlyphBitmaps[code - GlyphFirst];
    for (col = 0; col < 5; col++) begin
      column = bitmap[39 - 8 * col -: 8];
      px = ox + col;
      for (row = 0; row < 7; row++) begin
        py = oy + row;
        if (column[row] && px >= 0 && px < SCREEN_WIDTH && py >= 0 && py < SCREEN_HEIGHT) begin
          w.address = 16'(py * SCREEN_WIDTH + px);
          w.color   = ink;
          w.is_last = 1'b0;
          glyph_writes.push_back(w);
        end
      end
    end
    if (glyph_writes.size() > 0) glyph_writes[glyph_writes.size() - 1].is_last = 1'b1;
    foreach (glyph_writes[i]) expected_writes.push_back(glyph_writes[i]);
  endfunction

  always @(posedge clk) begin
    pixel_write_t want;
    if (!rst) begin
      if (pix_valid && !pix_stall) begin
        if (expected_writes.size() == 0) begin
          $display("%0t: unexpected write: expected none, got addr %h color %h last %b",
                   $time, pixel_address, pixel_color, last_pixel);
          errors++;
        end else begin
          want = expected_writes.pop_front();
          if (pixel_address !== want.address || pixel_color !== want.color ||
              last_pixel !== want.is_last) begin
            $display("%0t: write %0d: expected addr %h color %h last %b, got %h %h %b",
                     $time, checked, want.address, want.color, want.is_last,
                     pixel_address, pixel_color, last_pixel);
            errors++;
          end
          checked++;
        end
      end
      if (cmd_valid && !cmd_stall) render_glyph(origin_x, origin_y, ink_color, char_code);
    end
    fail_count     <= errors;
    writes_checked <= checked;
    writes_pending <= expected_writes.size();
  end

endmodule

// ===== dv/glyph_pixel_renderer_core_test.sv =====
`timescale 1ns / 1ps
// Testbench top for the 5x7 character generator: clock, reset, draw command
// stimulus, write-side stall and the verdict. Depends on gpr_pkg, the core
// and glyph_pixel_renderer_checker.
module glyph_pixel_renderer_core_test;
  import gpr_pkg::*;

  localparam int ItemsPerPhase = 76;
  // Cycles with no handshake on either channel before the run is abandoned.
  localparam int StallLimit = 2000;
  // Drain tail: a command without writes can still be in the ROM stage.
  localparam int TailCycles = 40;

  logic        clk = 1'b0;
  logic        rst;
  logic        cmd_valid;
  logic        cmd_stall;
  logic [9:0]  origin_x;
  logic [9:0]  origin_y;
  logic [31:0] ink_color;
  logic [7:0]  char_code;
  logic        pix_valid;
  logic        pix_stall;
  logic [15:0] pixel_address;
  logic [31:0] pixel_color;
  logic        last_pixel;

  int fail_count;
  int writes_pending;
  int writes_checked;

  int tx_idle_pct   = 0;   // chance per cycle that the command side holds off
  int rx_idle_pct   = 0;   // chance per cycle that the write side stalls
  int cmds_sent     = 0;
  int quiet_cycles  = 0;

  always #4 clk = ~clk;

  glyph_pixel_renderer_core dut (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .origin_x     (origin_x),
    .origin_y     (origin_y),
    .ink_color    (ink_color),
    .char_code    (char_code),
    .pix_valid    (pix_valid),
    .pix_stall    (pix_stall),
    .pixel_address(pixel_address),
    .pixel_color  (pixel_color),
    .last_pixel   (last_pixel)
  );

  glyph_pixel_renderer_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_stall     (cmd_stall),
    .origin_x      (origin_x),
    .origin_y      (origin_y),
    .ink_color     (ink_color),
    .char_code     (char_code),
    .pix_valid     (pix_valid),
    .pix_stall     (pix_stall),
    .pixel_address (pixel_address),
    .pixel_color   (pixel_color),
    .last_pixel    (last_pixel),
    .fail_count    (fail_count),
    .writes_pending(writes_pending),
    .writes_checked(writes_checked)
  );

  // Write-side back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    if (rst) pix_stall <= 1'b0;
    else     pix_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // Watchdog: restarts on any handshake, so only a hung channel trips it.
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (pix_valid && !pix_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: no handshake for %0d cycles, %0d writes outstanding",
               $time, StallLimit, writes_pending);
      $display("status: fail");
      $finish;
    end
  end

  // Presents one draw command and returns on the edge that takes it. The
  // idle loop lowers valid cycle by cycle; with no idle the new payload
  // follows the previous item back to back, valid staying high.
  task automatic send_cmd(input int x, input int y, input logic [31:0] ink,
                          input logic [7:0] code);
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    origin_x  <= 10'(x);
    origin_y  <= 10'(y);
    ink_color <= ink;
    char_code <= code;
    do @(posedge clk); while (cmd_stall);
    cmds_sent++;
  endtask

  // Drops valid and holds the command side until every write has come back.
  // The first wait lets the checker count the command just taken.
  task automatic wait_for_drain();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (writes_pending != 0);
  endtask

  // Origins cluster on screen and around both edges so that clipping is
  // common; a share of fully random 10-bit values exercises every bit.
  function automatic int pick_origin(input int extent);
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return $urandom_range(extent - 7, 0);
    if (roll < 70) return int'($urandom_range(11)) - 7;
    if (roll < 85) return extent - 6 + int'($urandom_range(11));
    return $signed(10'($urandom));
  endfunction

  function automatic logic [7:0] pick_code();
    if ($urandom_range(99) < 80) return 8'($urandom_range(GlyphLast, GlyphFirst));
    return 8'($urandom);
  endfunction

  task automatic send_random_cmds(input int count);
    repeat (count) send_cmd(pick_origin(256), pick_origin(256), $urandom, pick_code());
  endtask

  initial begin
    rst       = 1'b1;
    cmd_valid = 1'b0;
    origin_x  = '0;
    origin_y  = '0;
    ink_color = '0;
    char_code = '0;
    pix_stall = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Phase one pacing: the command side idles less than the write side.
    tx_idle_pct = 35;
    rx_idle_pct <= 51;

    // Directed: corners, clipping on each edge, blank and non-printable codes.
    send_cmd(0, 0, 32'hFFFF_FFFF, 8'h41);      // 'A' at the origin
    send_cmd(251, 249, 32'h0000_0000, 8'h23);  // '#' flush with bottom right
    send_cmd(253, 0, 32'hAAAA_AAAA, 8'h23);    // right edge cuts columns
    send_cmd(-2, 10, 32'h5555_5555, 8'h4D);    // left edge cuts columns
    send_cmd(10, -3, 32'h1234_5678, 8'h67);    // top edge cuts rows
    send_cmd(10, 252, 32'h8765_4321, 8'h42);   // bottom edge cuts rows
    send_cmd(-1, -1, 32'hDEAD_BEEF, 8'h23);    // both top and left cut
    send_cmd(255, 255, 32'hFFFF_FFFF, 8'h42);  // single visible pixel
    send_cmd(-512, -512, 32'hFFFF_FFFF, 8'h41);// most negative: all clipped
    send_cmd(511, 511, 32'hFFFF_FFFF, 8'h41);  // most positive: all clipped
    send_cmd(256, 0, 32'h0F0F_0F0F, 8'h57);    // just off the right edge
    send_cmd(-5, 0, 32'hF0F0_F0F0, 8'h57);     // just off the left edge
    send_cmd(0, 256, 32'h0F0F_0F0F, 8'h57);    // just below the bottom
    send_cmd(0, -7, 32'hF0F0_F0F0, 8'h57);     // just above the top
    send_cmd(0, 0, 32'hFFFF_FFFF, 8'h20);      // space: blank glyph
    send_cmd(0, 0, 32'hFFFF_FFFF, 8'h00);      // non-printable, low end
    send_cmd(0, 0, 32'hFFFF_FFFF, 8'h1F);      // one below the printable range
    send_cmd(0, 0, 32'hFFFF_FFFF, 8'h7F);      // one above the printable range
    send_cmd(0, 0, 32'hFFFF_FFFF, 8'h80);
    send_cmd(0, 0, 32'hFFFF_FFFF, 8'hFF);
    send_cmd(100, 100, 32'h0000_0001, 8'h21);  // first drawn glyph
    send_cmd(100, 100, 32'h8000_0000, 8'h7E);  // last glyph in the table
    send_cmd(120, 40, 32'hC0FF_EE00, 8'h40);   // dense glyph

    send_random_cmds(ItemsPerPhase);
    wait_for_drain();

    // Phase two: pacing swapped between the two sides.
    tx_idle_pct = 51;
    rx_idle_pct <= 35;
    send_random_cmds(ItemsPerPhase);
    wait_for_drain();

    // Phase three: both sides at full rate.
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    send_random_cmds(ItemsPerPhase);

    wait_for_drain();
    repeat (TailCycles) @(posedge clk);

    $display("covered %0d draw commands and %0d pixel writes: clipping on all edges,",
             cmds_sent, writes_checked);
    $display("blank and non-printable codes, under three idle and stall patterns");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/gpr_pkg.sv
hdl/gpr_font_rom.sv
hdl/glyph_pixel_renderer_core.sv
dv/glyph_pixel_renderer_checker.sv
dv/glyph_pixel_renderer_core_test.sv
